// ----- design/bb3_pkg.sv -----
// shared types, constants and the divisor reciprocal table for the 3x3 box blur
package bb3_pkg;

   localparam int PIX_W          = 8;
   localparam int WIN_ROWS       = 3;
   localparam int WIN_COLS       = 3;
   localparam int CSUM_W         = 10;
   localparam int RSUM_W         = 12;
   localparam int NUM_W          = 13;
   localparam int RECIP_W        = 21;
   localparam int MUL_SHIFT      = 21;
   localparam int PROD_W         = NUM_W + RECIP_W;
   localparam int WIDTH_REG_W    = 11;
   localparam int HEIGHT_REG_W   = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int OUT_ROW_W      = 12;
   localparam int OUT_COL_W      = 10;
   localparam int RESET_WIDTH    = 640;
   localparam int RESET_HEIGHT   = 480;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int FIFO_DEPTH     = 8;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_idx_type;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   // index 0 is the top window row
   typedef pixel_type [WIN_ROWS-1:0] column_type;

   typedef struct packed {
      logic [CSUM_W-1:0] blue;
      logic [CSUM_W-1:0] green;
      logic [CSUM_W-1:0] red;
   } colsum_type;

   typedef struct packed {
      logic                  en;
      logic [WIN_COLS-1:0]   col_mask;
      logic [OUT_ROW_W-1:0]  row;
      logic [OUT_COL_W-1:0]  col;
      logic                  run_last;
      logic                  frame_done;
   } res_ctl_type;

   typedef struct packed {
      res_ctl_type           a;
      res_ctl_type           b;
      logic [WIN_ROWS-1:0]   row_mask;
   } ctl_type;

   typedef struct packed {
      logic                  frame_done;
      logic                  run_last;
      logic [OUT_COL_W-1:0]  col;
      logic [OUT_ROW_W-1:0]  row;
      logic [PIX_W-1:0]      blue;
      logic [PIX_W-1:0]      green;
      logic [PIX_W-1:0]      red;
   } result_type;

   // ceil(2^21 / (2n)); exact quotient for numerators up to 2*2295+9
   function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
      logic [RECIP_W-1:0] m;
      case (n)
         4'd1:    m = 21'd1048576;
         4'd2:    m = 21'd524288;
         4'd3:    m = 21'd349526;
         4'd4:    m = 21'd262144;
         4'd5:    m = 21'd209716;
         4'd6:    m = 21'd174763;
         4'd7:    m = 21'd149797;
         4'd8:    m = 21'd131072;
         4'd9:    m = 21'd116509;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

// ----- design/bb3_ram.sv -----
// generic single-write, single-read ram with registered read data
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bb3_cell.sv -----
// one window column cell: holds three pixels and their masked per-channel column sum
module bb3_cell (
   input  logic                                    clock,
   input  logic                                    shift_en,
   input  logic [bb3_pkg::WIN_ROWS-1:0]            row_mask,
   input  bb3_pkg::column_type                     col_in,
   output bb3_pkg::column_type                     col_out,
   output bb3_pkg::colsum_type                     sum_out
);

   bb3_pkg::column_type col_ff;
   bb3_pkg::colsum_type sum_ff;
   bb3_pkg::colsum_type sum_in;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < bb3_pkg::WIN_ROWS; k++) begin
         if (row_mask[k]) begin
            sum_in.red   = sum_in.red   + bb3_pkg::CSUM_W'(col_in[k].red);
            sum_in.green = sum_in.green + bb3_pkg::CSUM_W'(col_in[k].green);
            sum_in.blue  = sum_in.blue  + bb3_pkg::CSUM_W'(col_in[k].blue);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
         sum_ff <= sum_in;
      end
   end

   assign col_out = col_ff;
   assign sum_out = sum_ff;

endmodule

// ----- design/bb3_mean.sv -----
// column sums to rounded means: masked sum and reciprocal lookup, then multiply
module bb3_mean (
   input  logic                                    clock,
   input  logic                                    reset,
   input  bb3_pkg::ctl_type                        ctl,
   input  bb3_pkg::colsum_type [bb3_pkg::WIN_COLS-1:0] col_sums,
   output logic                                    push_a,
   output bb3_pkg::result_type                     res_a,
   output logic                                    push_b,
   output bb3_pkg::result_type                     res_b
);

   bb3_pkg::res_ctl_type          rc          [2];
   logic                          en_in       [2];
   logic                          en_ff       [2];
   bb3_pkg::res_ctl_type          meta_ff     [2];
   logic [bb3_pkg::NUM_W-1:0]     xr_in       [2];
   logic [bb3_pkg::NUM_W-1:0]     xg_in       [2];
   logic [bb3_pkg::NUM_W-1:0]     xb_in       [2];
   logic [bb3_pkg::NUM_W-1:0]     xr_ff       [2];
   logic [bb3_pkg::NUM_W-1:0]     xg_ff       [2];
   logic [bb3_pkg::NUM_W-1:0]     xb_ff       [2];
   logic [bb3_pkg::RECIP_W-1:0]   m_in        [2];
   logic [bb3_pkg::RECIP_W-1:0]   m_ff        [2];
   bb3_pkg::result_type           res         [2];
   logic [1:0]                    rows;
   logic [1:0]                    cols;
   logic [3:0]                    n;
   logic [bb3_pkg::RSUM_W-1:0]    sr;
   logic [bb3_pkg::RSUM_W-1:0]    sg;
   logic [bb3_pkg::RSUM_W-1:0]    sb;
   logic [bb3_pkg::PROD_W-1:0]    pr;
   logic [bb3_pkg::PROD_W-1:0]    pg;
   logic [bb3_pkg::PROD_W-1:0]    pb;

   assign rc[0] = ctl.a;
   assign rc[1] = ctl.b;

   always_comb begin
      rows = 2'(ctl.row_mask[0]) + 2'(ctl.row_mask[1]) + 2'(ctl.row_mask[2]);
      for (int r = 0; r < 2; r++) begin
         cols = 2'(rc[r].col_mask[0]) + 2'(rc[r].col_mask[1]) + 2'(rc[r].col_mask[2]);
         n    = 4'(rows) * 4'(cols);
         sr   = '0;
         sg   = '0;
         sb   = '0;
         for (int k = 0; k < bb3_pkg::WIN_COLS; k++) begin
            if (rc[r].col_mask[k]) begin
               sr = sr + bb3_pkg::RSUM_W'(col_sums[k].red);
               sg = sg + bb3_pkg::RSUM_W'(col_sums[k].green);
               sb = sb + bb3_pkg::RSUM_W'(col_sums[k].blue);
            end
         end
         // 2*sum + n, later divided by 2n
         xr_in[r] = bb3_pkg::NUM_W'({sr, 1'b0}) + bb3_pkg::NUM_W'(n);
         xg_in[r] = bb3_pkg::NUM_W'({sg, 1'b0}) + bb3_pkg::NUM_W'(n);
         xb_in[r] = bb3_pkg::NUM_W'({sb, 1'b0}) + bb3_pkg::NUM_W'(n);
         m_in[r]  = bb3_pkg::recip(n);
         en_in[r] = rc[r].en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff[0] <= 1'b0;
         en_ff[1] <= 1'b0;
      end else begin
         en_ff[0] <= en_in[0];
         en_ff[1] <= en_in[1];
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 2; r++) begin
         meta_ff[r] <= rc[r];
         xr_ff[r]   <= xr_in[r];
         xg_ff[r]   <= xg_in[r];
         xb_ff[r]   <= xb_in[r];
         m_ff[r]    <= m_in[r];
      end
   end

   always_comb begin
      for (int r = 0; r < 2; r++) begin
         pr = bb3_pkg::PROD_W'(xr_ff[r]) * bb3_pkg::PROD_W'(m_ff[r]);
         pg = bb3_pkg::PROD_W'(xg_ff[r]) * bb3_pkg::PROD_W'(m_ff[r]);
         pb = bb3_pkg::PROD_W'(xb_ff[r]) * bb3_pkg::PROD_W'(m_ff[r]);
         res[r].red        = pr[bb3_pkg::MUL_SHIFT +: bb3_pkg::PIX_W];
         res[r].green      = pg[bb3_pkg::MUL_SHIFT +: bb3_pkg::PIX_W];
         res[r].blue       = pb[bb3_pkg::MUL_SHIFT +: bb3_pkg::PIX_W];
         res[r].row        = meta_ff[r].row;
         res[r].col        = meta_ff[r].col;
         res[r].run_last   = meta_ff[r].run_last;
         res[r].frame_done = meta_ff[r].frame_done;
      end
   end

   assign push_a = en_ff[0];
   assign res_a  = res[0];
   assign push_b = en_ff[1];
   assign res_b  = res[1];

endmodule

// ----- design/bb3_out_fifo.sv -----
// response queue taking up to two entries per cycle and giving one while out_ready is high
module bb3_out_fifo #(
   parameter int DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_a,
   input  bb3_pkg::result_type  data_a,
   input  logic                 push_b,
   input  bb3_pkg::result_type  data_b,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bb3_pkg::result_type  out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bb3_pkg::result_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [PTR_W-1:0]    b_addr;
   logic [PTR_W-1:0]    wr_next;
   logic [PTR_W-1:0]    rd_next;
   logic                pop;

   assign pop = out_valid && out_ready;

   always_comb begin
      wr_next   = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      rd_next   = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      b_addr    = push_a ? wr_next : wr_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (push_a && push_b) begin
         wr_ptr_in = (32'(b_addr) == DEPTH - 1) ? '0 : b_addr + PTR_W'(1);
      end else if (push_a || push_b) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = pop ? rd_next : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         mem_ff[wr_ptr_ff] <= data_a;
      end
      if (push_b) begin
         mem_ff[b_addr] <= data_b;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];

endmodule

// ----- design/box_blur_3x3_rgb.sv -----
// 3x3 box blur of an rgb pixel stream: top level with line stores, window cells and control
//
// Pixels arrive in raster order, one request per clock. Each response is the rounded
// (half up) mean of a pixel's in-frame 3x3 neighbourhood, per channel, and trails the
// input by one row plus one pixel; a drain request pushes out one pixel of the frame's
// final row. A request is taken in the cycle it arrives, so a pixel is taken every clock
// while responses are taken every clock; a pixel in the last column gives two responses,
// which the 8-entry response queue absorbs without holding the input. The input is held
// only during reset or while responses back up behind a low rsp_tready. Responses are
// registered in the window cells, the mean stage and the queue. Two line stores of
// MAX_WIDTH entries keep the two rows above the incoming one. A write to either csr
// restarts the frame; csr writes are for an idle block only. No clearing pass is needed.
module box_blur_3x3_rgb #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [23:0]                        req_tdata,   // in_red, in_green, in_blue
   input  logic                               req_tuser,   // cmd
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [47:0]                        rsp_tdata,   // out_red, out_green, out_blue,
                                                           // out_row, out_col, zero pad
   output logic                               rsp_tlast,   // run_last
   output logic                               rsp_tuser,   // frame_done
   input  logic                               csr_wr_en,
   input  bb3_pkg::csr_idx_type               csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int CW1      = COL_W + 1;
   localparam int RW1      = ROW_W + 1;
   localparam int CREDIT_W = $clog2(bb3_pkg::FIFO_DEPTH + 1);
   localparam int PIXEL_W  = $bits(bb3_pkg::pixel_type);

   logic [bb3_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [bb3_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]                 in_col_ff, in_col_in;
   logic [ROW_W-1:0]                 in_row_ff, in_row_in;
   logic [COL_W-1:0]                 emit_col_ff, emit_col_in;
   logic                             tail_ff, tail_in;
   logic [CREDIT_W-1:0]              credit_ff, credit_in;
   bb3_pkg::ctl_type                 ctl_ff, ctl_in;
   bb3_pkg::column_type              first_col_ff, first_col_in;
   logic                             byp_hit_ff, byp_hit_in;
   bb3_pkg::pixel_type               byp_upper_ff, byp_lower_ff;

   logic [CW1-1:0]                   w_eff;
   logic [RW1-1:0]                   h_eff;
   logic                             accept;
   bb3_pkg::pixel_type               px;
   bb3_pkg::pixel_type               upper_q, lower_q;
   bb3_pkg::pixel_type               upper_rd, lower_rd;
   logic [COL_W-1:0]                 rd_addr;
   logic                             wr_en;
   logic                             shift_en;
   logic                             load_first;
   logic [bb3_pkg::WIN_ROWS-1:0]     row_mask;
   bb3_pkg::column_type              new_col;
   bb3_pkg::column_type              cell_in  [bb3_pkg::WIN_COLS];
   bb3_pkg::column_type              cell_q   [bb3_pkg::WIN_COLS];
   bb3_pkg::colsum_type [bb3_pkg::WIN_COLS-1:0] cell_sum;
   logic [1:0]                       n_res;
   logic [CW1-1:0]                   col_inc;
   logic [RW1-1:0]                   row_inc;
   logic [CW1-1:0]                   emit_inc;
   logic                             push_a, push_b;
   bb3_pkg::result_type              res_a, res_b, q_data;
   logic                             pop;

   // effective frame size: zero acts as one, too large acts as the maximum
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CW1'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = CW1'(MAX_WIDTH);
      end else begin
         w_eff = CW1'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = RW1'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = RW1'(MAX_HEIGHT);
      end else begin
         h_eff = RW1'(height_ff);
      end
   end

   assign req_tready = !reset && (credit_ff <= CREDIT_W'(bb3_pkg::FIFO_DEPTH - 2));
   assign accept     = req_tvalid && req_tready;
   assign px         = bb3_pkg::pixel_type'(req_tdata);
   assign upper_rd   = byp_hit_ff ? byp_upper_ff : upper_q;
   assign lower_rd   = byp_hit_ff ? byp_lower_ff : lower_q;
   assign col_inc    = CW1'(in_col_ff) + CW1'(1);
   assign row_inc    = RW1'(in_row_ff) + RW1'(1);
   assign emit_inc   = CW1'(emit_col_ff) + CW1'(1);

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      emit_col_in  = emit_col_ff;
      tail_in      = tail_ff;
      ctl_in       = '0;
      first_col_in = first_col_ff;
      row_mask     = '0;
      new_col      = '0;
      shift_en     = 1'b0;
      load_first   = 1'b0;
      wr_en        = 1'b0;
      n_res        = '0;
      if (csr_wr_en) begin
         case (csr_index)
            bb3_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_wdata[bb3_pkg::WIDTH_REG_W-1:0];
            bb3_pkg::CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
         in_col_in   = '0;
         in_row_in   = '0;
         emit_col_in = '0;
         tail_in     = 1'b0;
      end else if (accept) begin
         if (bb3_pkg::cmd_type'(req_tuser) == bb3_pkg::CMD_DRAIN) begin
            if (tail_ff) begin
               // final row: window rows are the two stored rows, nothing below
               shift_en           = 1'b1;
               load_first         = (emit_col_ff == '0);
               new_col[0]         = upper_rd;
               new_col[1]         = lower_rd;
               row_mask           = {1'b0, 1'b1, (h_eff >= RW1'(2))};
               ctl_in.a.en        = 1'b1;
               ctl_in.a.col_mask  = {(emit_inc < w_eff), 1'b1, (emit_col_ff != '0)};
               ctl_in.a.row       = bb3_pkg::OUT_ROW_W'(h_eff - RW1'(1));
               ctl_in.a.col       = bb3_pkg::OUT_COL_W'(emit_col_ff);
               ctl_in.a.run_last  = 1'b1;
               ctl_in.a.frame_done = (emit_inc == w_eff);
               n_res              = 2'd1;
               if (emit_inc >= w_eff) begin
                  tail_in     = 1'b0;
                  emit_col_in = '0;
               end else begin
                  emit_col_in = COL_W'(emit_inc);
               end
            end
         end else begin
            tail_in     = 1'b0;
            emit_col_in = '0;
            shift_en    = 1'b1;
            wr_en       = 1'b1;
            new_col[0]  = upper_rd;
            new_col[1]  = lower_rd;
            new_col[2]  = px;
            row_mask    = {1'b1, 1'b1, (in_row_ff > ROW_W'(1))};
            if (in_row_ff != '0) begin
               ctl_in.a.en       = (in_col_ff != '0);
               ctl_in.a.col_mask = {1'b1, 1'b1, (in_col_ff > COL_W'(1))};
               ctl_in.a.row      = bb3_pkg::OUT_ROW_W'(in_row_ff - ROW_W'(1));
               ctl_in.a.col      = bb3_pkg::OUT_COL_W'(in_col_ff - COL_W'(1));
               ctl_in.a.run_last = (col_inc < w_eff);
               ctl_in.b.en       = (col_inc >= w_eff);
               ctl_in.b.col_mask = {1'b1, (in_col_ff != '0), 1'b0};
               ctl_in.b.row      = bb3_pkg::OUT_ROW_W'(in_row_ff - ROW_W'(1));
               ctl_in.b.col      = bb3_pkg::OUT_COL_W'(in_col_ff);
               ctl_in.b.run_last = 1'b1;
               n_res = 2'(ctl_in.a.en) + 2'(ctl_in.b.en);
            end
            // keep column 0 of the last two rows for the first drain
            if (row_inc == h_eff && in_col_ff == '0) begin
               first_col_in[0] = lower_rd;
               first_col_in[1] = px;
               first_col_in[2] = '0;
            end
            if (col_inc >= w_eff) begin
               in_col_in = '0;
               if (row_inc >= h_eff) begin
                  in_row_in = '0;
                  tail_in   = 1'b1;
               end else begin
                  in_row_in = ROW_W'(row_inc);
               end
            end else begin
               in_col_in = COL_W'(col_inc);
            end
         end
      end
      ctl_in.row_mask = row_mask;
   end

   // line store read address runs one step ahead; same-address write is forwarded
   always_comb begin
      rd_addr    = tail_in ? COL_W'(CW1'(emit_col_in) + CW1'(1)) : in_col_in;
      byp_hit_in = wr_en && (rd_addr == in_col_ff);
   end

   assign pop       = rsp_tvalid && rsp_tready;
   assign credit_in = credit_ff + CREDIT_W'(n_res) - CREDIT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= bb3_pkg::WIDTH_REG_W'(bb3_pkg::RESET_WIDTH);
         height_ff   <= bb3_pkg::HEIGHT_REG_W'(bb3_pkg::RESET_HEIGHT);
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         emit_col_ff <= '0;
         tail_ff     <= 1'b0;
         credit_ff   <= '0;
         ctl_ff      <= '0;
         byp_hit_ff  <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         emit_col_ff <= emit_col_in;
         tail_ff     <= tail_in;
         credit_ff   <= credit_in;
         ctl_ff      <= ctl_in;
         byp_hit_ff  <= byp_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      first_col_ff <= first_col_in;
      byp_upper_ff <= lower_rd;
      byp_lower_ff <= px;
   end

   bb3_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_upper_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (in_col_ff),
      .wr_data (lower_rd),
      .rd_addr (rd_addr),
      .rd_data (upper_q)
   );

   bb3_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_lower_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (in_col_ff),
      .wr_data (px),
      .rd_addr (rd_addr),
      .rd_data (lower_q)
   );

   // window cells: cell 2 takes the new column, cell 1 takes cell 2 or first_col, cell 0 cell 1
   always_comb begin
      cell_in[2] = new_col;
      cell_in[1] = load_first ? first_col_ff : cell_q[2];
      cell_in[0] = cell_q[1];
   end

   for (genvar k = 0; k < bb3_pkg::WIN_COLS; k++) begin : g_cell
      bb3_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .row_mask (row_mask),
         .col_in   (cell_in[k]),
         .col_out  (cell_q[k]),
         .sum_out  (cell_sum[k])
      );
   end

   bb3_mean u_mean (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_ff),
      .col_sums (cell_sum),
      .push_a   (push_a),
      .res_a    (res_a),
      .push_b   (push_b),
      .res_b    (res_b)
   );

   bb3_out_fifo #(
      .DEPTH (bb3_pkg::FIFO_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_a    (push_a),
      .data_a    (res_a),
      .push_b    (push_b),
      .data_b    (res_b),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (q_data)
   );

   assign rsp_tdata = {2'b00, q_data.col, q_data.row, q_data.blue, q_data.green, q_data.red};
   assign rsp_tlast = q_data.run_last;
   assign rsp_tuser = q_data.frame_done;

endmodule
